/* rtl/ase_pkg.sv */
// Shared types, constants and helper functions of the after-start enrichment block.
`default_nettype none

package ase_pkg;

    localparam int RPM_W     = 16;
    localparam int TIME_W    = 32;
    localparam int WIDTH_W   = 16;
    localparam int PCT_W     = 8;
    localparam int CNT_W     = 16;
    localparam int PROD_W    = 24;
    localparam int DIVISOR_W = 16;
    localparam int DIV_STEPS = 3;

    // Division by 100 as a multiplication by a scaled reciprocal.
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int QUOT100_W   = SCALED_W - RECIP_SHIFT;

    localparam logic [RPM_W-1:0]   START_RPM_RST = 16'd600;
    localparam logic [RPM_W-1:0]   STOP_RPM_RST  = 16'd300;
    localparam logic [15:0]        STABLE_MS_RST = 16'd100;
    localparam logic [CNT_W-1:0]   DURATION_RST  = 16'd200;
    localparam logic [PCT_W-1:0]   PEAK_RST      = 8'd120;

    localparam logic [PCT_W-1:0]     PCT_UNITY   = 8'd100;
    localparam logic [PCT_W-1:0]     PCT_MAX     = 8'd255;
    localparam logic [PROD_W-1:0]    EXTRA_MAX   = 24'd155;
    localparam logic [WIDTH_W-1:0]   WIDTH_MAX   = 16'hFFFF;

    // ceil(2**31 / 100); the scaled product gives the exact quotient for every
    // dividend below 2**24.
    localparam logic [RECIP_W-1:0]   RECIP_100   = 25'd21474837;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_START_RPM = 3'd0;
    localparam logic [2:0] REG_STOP_RPM  = 3'd1;
    localparam logic [2:0] REG_STABLE_MS = 3'd2;
    localparam logic [2:0] REG_DURATION  = 3'd3;
    localparam logic [2:0] REG_PEAK      = 3'd4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_APPLY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_PCT_MUL,
        S_PCT_DIV,
        S_PCT_WAIT,
        S_W_MUL,
        S_W_DIV,
        S_W_FIN,
        S_DONE
    } ase_state_t;

    typedef enum logic [1:0] {
        PCT_FROM_UNITY,
        PCT_FROM_SPAN,
        PCT_FROM_QUOT
    } pct_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     do_update;
        logic     mul_pct;
        logic     div_start;
        logic     load_pct;
        pct_sel_t pct_sel;
        logic     mul_width;
        logic     scale_width;
        logic     finish_apply;
        logic     load_out;
    } ase_cmd_t;

    typedef struct packed {
        logic cd_zero;
        logic dur_zero;
        logic div_done;
    } ase_stat_t;

    // 100 plus the extra percent, clipped at 255.
    function automatic logic [PCT_W-1:0] sat_pct(input logic [PROD_W-1:0] extra);
        logic [PCT_W-1:0] pct;
        if (extra > EXTRA_MAX)
        begin
            pct = PCT_MAX;
        end
        else
        begin
            pct = PCT_UNITY + extra[PCT_W-1:0];
        end
        return pct;
    endfunction

    function automatic logic [WIDTH_W-1:0] sat_width(input logic [QUOT100_W-1:0] value);
        logic [WIDTH_W-1:0] w;
        if (value[QUOT100_W-1:WIDTH_W] != '0)
        begin
            w = WIDTH_MAX;
        end
        else
        begin
            w = value[WIDTH_W-1:0];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/ase_div.sv */
// Iterative unsigned divider, three quotient bits per clock cycle.
`default_nettype none

module ase_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [ase_pkg::PROD_W-1:0]            dividend,
    input  wire logic [ase_pkg::DIVISOR_W-1:0]         divisor,
    output logic                                       done,
    output logic [ase_pkg::PROD_W-1:0]                 quotient
);

    localparam int ITERS = ase_pkg::PROD_W / ase_pkg::DIV_STEPS;
    localparam int ITER_W = $clog2(ITERS);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITERS - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ITER_W-1:0]                 iter_reg, iter_next;
    logic [ase_pkg::DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [ase_pkg::PROD_W-1:0]        quo_reg, quo_next;
    logic [ase_pkg::DIVISOR_W-1:0]     dvsr_reg, dvsr_next;
    logic [ase_pkg::DIVISOR_W:0]       r;
    logic [ase_pkg::PROD_W-1:0]        q;

    // Restoring division: the dividend shifts out of the top of quo_reg while
    // quotient bits shift in at the bottom.
    always_comb
    begin
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < ase_pkg::DIV_STEPS; i++)
        begin
            r = {r[ase_pkg::DIVISOR_W-1:0], q[ase_pkg::PROD_W-1]};
            q = {q[ase_pkg::PROD_W-2:0], 1'b0};
            if (r >= {1'b0, dvsr_reg})
            begin
                r = r - {1'b0, dvsr_reg};
                q[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = r[ase_pkg::DIVISOR_W-1:0];
            quo_next  = q;
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/ase_dp.sv */
// Datapath: start detection state, countdown, percent and pulse width arithmetic.
`default_nettype none

module ase_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ase_pkg::ase_cmd_t                 cmd,
    output ase_pkg::ase_stat_t                     stat,
    input  wire logic [ase_pkg::RPM_W-1:0]         in_rpm,
    input  wire logic [ase_pkg::TIME_W-1:0]        in_time,
    input  wire logic [ase_pkg::WIDTH_W-1:0]       in_base,
    input  wire logic [ase_pkg::RPM_W-1:0]         start_rpm,
    input  wire logic [ase_pkg::RPM_W-1:0]         stop_rpm,
    input  wire logic [15:0]                       stable_ms,
    input  wire logic [ase_pkg::CNT_W-1:0]         duration_cycles,
    input  wire logic [ase_pkg::PCT_W-1:0]         peak_percent,
    output logic                                   out_active,
    output logic [ase_pkg::WIDTH_W-1:0]            out_width,
    output logic [ase_pkg::PCT_W-1:0]              out_pct
);

    // Control state of the enrichment.
    logic [ase_pkg::CNT_W-1:0]    countdown_reg, countdown_next;
    logic                         engine_on_reg, engine_on_next;
    logic                         waiting_reg, waiting_next;
    logic [ase_pkg::TIME_W-1:0]   stamp_reg, stamp_next;
    logic [ase_pkg::PCT_W-1:0]    last_pct_reg, last_pct_next;

    // Working registers of one transaction.
    logic [ase_pkg::RPM_W-1:0]    rpm_reg;
    logic [ase_pkg::TIME_W-1:0]   time_reg;
    logic [ase_pkg::WIDTH_W-1:0]  base_reg;
    logic [ase_pkg::PROD_W-1:0]   prod_reg;
    logic [ase_pkg::QUOT100_W-1:0] quot100_reg;
    logic [ase_pkg::PCT_W-1:0]    pct_reg;
    logic                         res_active_reg;
    logic [ase_pkg::WIDTH_W-1:0]  res_width_reg;
    logic [ase_pkg::PCT_W-1:0]    res_pct_reg;
    logic                         out_active_reg;
    logic [ase_pkg::WIDTH_W-1:0]  out_width_reg;
    logic [ase_pkg::PCT_W-1:0]    out_pct_reg;

    logic                         high, arm, fire;
    logic [ase_pkg::TIME_W-1:0]   stamp_eff, elapsed;
    logic [ase_pkg::CNT_W-1:0]    cd_loaded;
    logic [ase_pkg::PCT_W-1:0]    span;
    logic [ase_pkg::PCT_W-1:0]    pct_sel_val;
    logic [ase_pkg::SCALED_W-1:0] scaled;
    logic                         div_done;
    logic [ase_pkg::PROD_W-1:0]   div_quot;

    ase_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (duration_cycles),
        .done     (div_done),
        .quotient (div_quot)
    );

    // The top bits of width*percent times the reciprocal are width*percent/100.
    assign scaled = {{ase_pkg::RECIP_W{1'b0}}, prod_reg}
                  * {{ase_pkg::PROD_W{1'b0}}, ase_pkg::RECIP_100};

    // A start is confirmed once rpm has been high for longer than stable_ms,
    // counted from the first update of the current unbroken run of high updates.
    always_comb
    begin
        high      = rpm_reg > start_rpm;
        arm       = high && !engine_on_reg;
        stamp_eff = waiting_reg ? stamp_reg : time_reg;
        elapsed   = time_reg - stamp_eff;
        fire      = arm && (elapsed > {16'b0, stable_ms});
        cd_loaded = fire ? duration_cycles : countdown_reg;
    end

    always_comb
    begin
        span = (peak_percent >= ase_pkg::PCT_UNITY) ? (peak_percent - ase_pkg::PCT_UNITY)
                                                    : '0;
        unique case (cmd.pct_sel)
            ase_pkg::PCT_FROM_UNITY: pct_sel_val = ase_pkg::PCT_UNITY;
            ase_pkg::PCT_FROM_SPAN:  pct_sel_val = ase_pkg::sat_pct({16'b0, span});
            ase_pkg::PCT_FROM_QUOT:  pct_sel_val = ase_pkg::sat_pct(div_quot);
            default:                 pct_sel_val = ase_pkg::PCT_UNITY;
        endcase
    end

    always_comb
    begin
        countdown_next = countdown_reg;
        engine_on_next = engine_on_reg;
        waiting_next   = waiting_reg;
        stamp_next     = stamp_reg;
        last_pct_next  = last_pct_reg;
        if (cmd.do_update)
        begin
            waiting_next   = arm && !fire;
            stamp_next     = (arm && !waiting_reg) ? time_reg : stamp_reg;
            engine_on_next = (fire || engine_on_reg) && !(rpm_reg < stop_rpm);
            countdown_next = (cd_loaded != '0) ? cd_loaded - 1'b1 : '0;
        end
        if (cmd.finish_apply)
        begin
            last_pct_next = pct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            engine_on_reg <= 1'b0;
            waiting_reg   <= 1'b0;
            stamp_reg     <= '0;
            last_pct_reg  <= ase_pkg::PCT_UNITY;
        end
        else
        begin
            countdown_reg <= countdown_next;
            engine_on_reg <= engine_on_next;
            waiting_reg   <= waiting_next;
            stamp_reg     <= stamp_next;
            last_pct_reg  <= last_pct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            rpm_reg  <= in_rpm;
            time_reg <= in_time;
            base_reg <= in_base;
        end
        if (cmd.mul_pct)
        begin
            prod_reg <= {8'b0, countdown_reg} * {16'b0, span};
        end
        else if (cmd.mul_width)
        begin
            prod_reg <= {8'b0, base_reg} * {16'b0, pct_reg};
        end
        if (cmd.scale_width)
        begin
            quot100_reg <= scaled[ase_pkg::SCALED_W-1:ase_pkg::RECIP_SHIFT];
        end
        if (cmd.load_pct)
        begin
            pct_reg <= pct_sel_val;
        end
        if (cmd.do_update)
        begin
            res_active_reg <= countdown_next != '0;
            res_width_reg  <= '0;
            res_pct_reg    <= last_pct_reg;
        end
        else if (cmd.finish_apply)
        begin
            res_active_reg <= countdown_reg != '0;
            res_width_reg  <= ase_pkg::sat_width(quot100_reg);
            res_pct_reg    <= pct_reg;
        end
        if (cmd.load_out)
        begin
            out_active_reg <= res_active_reg;
            out_width_reg  <= res_width_reg;
            out_pct_reg    <= res_pct_reg;
        end
    end

    assign stat.cd_zero  = countdown_reg == '0;
    assign stat.dur_zero = duration_cycles == '0;
    assign stat.div_done = div_done;

    assign out_active = out_active_reg;
    assign out_width  = out_width_reg;
    assign out_pct    = out_pct_reg;

endmodule

`default_nettype wire

/* rtl/ase_ctrl.sv */
// Controller state machine that sequences updates and applies through the datapath.
`default_nettype none

module ase_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_op,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire ase_pkg::ase_stat_t    stat,
    output ase_pkg::ase_cmd_t          cmd
);

    ase_pkg::ase_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ase_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == ase_pkg::OP_APPLY) ? ase_pkg::S_PCT_MUL
                                                              : ase_pkg::S_UPDATE;
                end
            end
            ase_pkg::S_UPDATE:   state_next = ase_pkg::S_DONE;
            ase_pkg::S_PCT_MUL:
            begin
                if (stat.cd_zero || stat.dur_zero)
                begin
                    state_next = ase_pkg::S_W_MUL;
                end
                else
                begin
                    state_next = ase_pkg::S_PCT_DIV;
                end
            end
            ase_pkg::S_PCT_DIV:  state_next = ase_pkg::S_PCT_WAIT;
            ase_pkg::S_PCT_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ase_pkg::S_W_MUL;
                end
            end
            ase_pkg::S_W_MUL:    state_next = ase_pkg::S_W_DIV;
            ase_pkg::S_W_DIV:    state_next = ase_pkg::S_W_FIN;
            ase_pkg::S_W_FIN:    state_next = ase_pkg::S_DONE;
            ase_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = ase_pkg::S_IDLE;
                end
            end
            default:             state_next = ase_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ase_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ase_pkg::S_UPDATE:
            begin
                cmd.do_update = 1'b1;
            end
            ase_pkg::S_PCT_MUL:
            begin
                cmd.mul_pct  = 1'b1;
                cmd.load_pct = stat.cd_zero || stat.dur_zero;
                cmd.pct_sel  = stat.cd_zero ? ase_pkg::PCT_FROM_UNITY
                                            : ase_pkg::PCT_FROM_SPAN;
            end
            ase_pkg::S_PCT_DIV:
            begin
                cmd.div_start = 1'b1;
            end
            ase_pkg::S_PCT_WAIT:
            begin
                cmd.load_pct = stat.div_done;
                cmd.pct_sel  = ase_pkg::PCT_FROM_QUOT;
            end
            ase_pkg::S_W_MUL:
            begin
                cmd.mul_width = 1'b1;
            end
            ase_pkg::S_W_DIV:
            begin
                cmd.scale_width = 1'b1;
            end
            ase_pkg::S_W_FIN:
            begin
                cmd.finish_apply = 1'b1;
            end
            ase_pkg::S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ase_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/after_start_enrichment.sv */
// After-start fuel enrichment. An update transaction (tuser 0) checks rpm and
// the millisecond timestamp. An apply transaction (tuser 1) scales the base
// pulse width by the current enrichment percent; the percent over 100 comes
// from countdown*span/duration in an iterative divider that produces three
// quotient bits per cycle; when the countdown or the duration is zero that
// division is skipped. The division of width*percent by 100 is a multiplication
// by a scaled reciprocal. The result is loaded into the output register once
// that register is free. One transaction is processed at a time; the next one
// is accepted in the cycle after the result is loaded, even while that result
// still sits in the output register.
`default_nettype none

module after_start_enrichment (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // rpm[15:0], time_ms[47:16], base_width[63:48]
    input  wire logic        s_tuser,  // op
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // active[0], enriched_width[16:1], percent_now[24:17]
);

    logic [ase_pkg::RPM_W-1:0]   start_rpm_reg;
    logic [ase_pkg::RPM_W-1:0]   stop_rpm_reg;
    logic [15:0]                 stable_ms_reg;
    logic [ase_pkg::CNT_W-1:0]   duration_reg;
    logic [ase_pkg::PCT_W-1:0]   peak_reg;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;

    ase_pkg::ase_cmd_t           cmd;
    ase_pkg::ase_stat_t          stat;
    logic                        out_active;
    logic [ase_pkg::WIDTH_W-1:0] out_width;
    logic [ase_pkg::PCT_W-1:0]   out_pct;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rpm_reg <= ase_pkg::START_RPM_RST;
            stop_rpm_reg  <= ase_pkg::STOP_RPM_RST;
            stable_ms_reg <= ase_pkg::STABLE_MS_RST;
            duration_reg  <= ase_pkg::DURATION_RST;
            peak_reg      <= ase_pkg::PEAK_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ase_pkg::REG_START_RPM: start_rpm_reg <= pwdata[15:0];
                ase_pkg::REG_STOP_RPM:  stop_rpm_reg  <= pwdata[15:0];
                ase_pkg::REG_STABLE_MS: stable_ms_reg <= pwdata[15:0];
                ase_pkg::REG_DURATION:  duration_reg  <= pwdata[15:0];
                ase_pkg::REG_PEAK:      peak_reg      <= pwdata[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            ase_pkg::REG_START_RPM: prdata = {16'b0, start_rpm_reg};
            ase_pkg::REG_STOP_RPM:  prdata = {16'b0, stop_rpm_reg};
            ase_pkg::REG_STABLE_MS: prdata = {16'b0, stable_ms_reg};
            ase_pkg::REG_DURATION:  prdata = {16'b0, duration_reg};
            ase_pkg::REG_PEAK:      prdata = {24'b0, peak_reg};
            default:                prdata = '0;
        endcase
    end

    ase_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ase_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_rpm          (s_tdata[15:0]),
        .in_time         (s_tdata[47:16]),
        .in_base         (s_tdata[63:48]),
        .start_rpm       (start_rpm_reg),
        .stop_rpm        (stop_rpm_reg),
        .stable_ms       (stable_ms_reg),
        .duration_cycles (duration_reg),
        .peak_percent    (peak_reg),
        .out_active      (out_active),
        .out_width       (out_width),
        .out_pct         (out_pct)
    );

    assign m_tdata = {7'b0, out_pct, out_width, out_active};

    // The percent reported is never below unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:17] >= ase_pkg::PCT_UNITY))
        else $error("percent_now below 100");

    // An apply with no countdown running passes the width at unity percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0] && (m_tdata[16:1] != 16'd0))
            |-> (m_tdata[24:17] == ase_pkg::PCT_UNITY))
        else $error("inactive apply used a percent other than 100");

    // Only one transaction is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in work");

endmodule

`default_nettype wire
